// ===== rtl/tsp_exhaustive_search_macros.svh =====
// assertion macros for the path search block
`ifndef TSP_EXHAUSTIVE_SEARCH_MACROS_SVH
`define TSP_EXHAUSTIVE_SEARCH_MACROS_SVH

// clocked implication check, reset disables
`define TSP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication check
`define TSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
package tsp_pkg;
  localparam int DistW = 16;
  localparam int TotW = 20;
  localparam int CityW = 4;
  localparam logic [TotW-1:0] TotAllOnes = {TotW{1'b1}};

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic init;     // clear search state, latch city count
    logic fetch;    // read matrix for current candidate
    logic eval;     // evaluate candidate with fetched distance
    logic emit_adv; // advance output position
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;     // search finished
    logic out_last; // output position is the last one
  } sts_t;
endpackage

// ===== rtl/tsp_ctrl.sv =====
`timescale 1ns / 1ps
module tsp_ctrl
  import tsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  input  logic out_ready,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EVAL;
      ST_EVAL: if (sts.done) state_next = ST_EMIT; else state_next = ST_FETCH;
      ST_EMIT: if (out_ready && sts.out_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.init = (state == ST_IDLE) && start;
    cmd.fetch = (state == ST_FETCH);
    cmd.eval = (state == ST_EVAL);
    cmd.emit_adv = (state == ST_EMIT) && out_ready;
    busy = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
  end
endmodule

// ===== rtl/tsp_dp.sv =====
`timescale 1ns / 1ps
module tsp_dp
  import tsp_pkg::*;
#(
  parameter int MaxCities = 12
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic ld_en,
  input  logic [CityW-1:0] ld_row,
  input  logic [CityW-1:0] ld_col,
  input  logic [DistW-1:0] ld_dist,
  input  logic [CityW-1:0] num_cities,
  output logic [CityW-1:0] route_city,
  output logic [CityW-1:0] route_position,
  output logic [TotW-1:0] best_length,
  output logic last_city
);
  localparam int Depth = MaxCities * MaxCities;
  localparam int AddrW = $clog2(Depth);

  logic [DistW-1:0] mem [Depth];
  logic [DistW-1:0] rd;

  logic [CityW-1:0] n;
  logic [CityW-1:0] depth;  // position being filled
  logic [CityW-1:0] cand;   // candidate city at that position
  logic [MaxCities-1:0] visited;
  logic [CityW-1:0] route [MaxCities];
  logic [TotW-1:0] plen [MaxCities];
  logic [TotW-1:0] best;
  logic [CityW-1:0] broute [MaxCities];
  logic [CityW-1:0] opos;
  logic done;

  function automatic logic [AddrW-1:0] addr(input logic [CityW-1:0] r,
                                            input logic [CityW-1:0] c);
    logic [AddrW+CityW-1:0] a;
    a = (AddrW+CityW)'(r) * (AddrW+CityW)'(MaxCities) + (AddrW+CityW)'(c);
    return a[AddrW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ld_en && (32'(ld_row) < MaxCities) && (32'(ld_col) < MaxCities))
      mem[addr(ld_row, ld_col)] <= ld_dist;
    if (cmd.fetch) rd <= mem[addr(route[depth - 1'b1], cand)];
  end

  logic [TotW-1:0] len;
  logic cand_ok, cand_end;
  assign len = plen[depth - 1'b1] + TotW'(rd);
  assign cand_end = (cand >= n);
  assign cand_ok = !cand_end && !visited[cand] && (len < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      best <= TotAllOnes;
      opos <= '0;
      n <= CityW'(2);
    end else if (cmd.init) begin
      if (num_cities < CityW'(2)) n <= CityW'(2);
      else if (32'(num_cities) > MaxCities) n <= CityW'(MaxCities);
      else n <= num_cities;
      depth <= CityW'(1);
      cand <= CityW'(1);
      visited <= MaxCities'(1);
      route[0] <= '0;
      plen[0] <= '0;
      best <= TotAllOnes;
      done <= 1'b0;
      opos <= '0;
    end else if (cmd.eval) begin
      if (cand_end) begin
        // backtrack
        if (depth == CityW'(1)) done <= 1'b1;
        else begin
          depth <= depth - 1'b1;
          visited[route[depth - 1'b1]] <= 1'b0;
          cand <= route[depth - 1'b1] + 1'b1;
        end
      end else if (cand_ok) begin
        if (depth + 1'b1 >= n) begin
          // complete path, strictly shorter by construction
          best <= len;
          for (int i = 0; i < MaxCities; i++)
            broute[i] <= (i == 32'(depth)) ? cand : route[i];
          cand <= cand + 1'b1;
        end else begin
          route[depth] <= cand;
          plen[depth] <= len;
          visited[cand] <= 1'b1;
          depth <= depth + 1'b1;
          cand <= CityW'(1);
        end
      end else cand <= cand + 1'b1;
    end else if (cmd.emit_adv) begin
      opos <= opos + 1'b1;
    end
  end

  assign sts.done = done || (cmd.eval && cand_end && depth == CityW'(1));
  assign sts.out_last = (opos == n - 1'b1);
  assign route_city = (opos == '0) ? '0 : broute[opos];
  assign route_position = opos;
  assign best_length = best;
  assign last_city = sts.out_last;
endmodule

// ===== rtl/tsp_exhaustive_search.sv =====
`timescale 1ns / 1ps
// exhaustive shortest open path search from city 0 over a directed matrix.
// load beats write one distance each into the matrix. a start beat runs a
// depth-first walk over all orderings of cities 1..n-1 in lexicographic
// order with pruning of partial paths that cannot beat the best; each
// candidate takes a matrix read, then an evaluate step, and each
// backtrack step does the same. every partial path of the walk tries
// candidates 1..n-1 in turn before it backtracks.
// the route then streams out one city per beat, tlast on the final one.
// input is not taken during a search or route output.
module tsp_exhaustive_search
  import tsp_pkg::*;
#(
  parameter int MAX_CITIES = 12
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // row_index[3:0], col_index[7:4], distance[23:8]
  input  logic s_axis_tuser,         // command
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // route_city[3:0], route_position[7:4], best_length[27:8]
  output logic m_axis_tlast,         // last_city
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data        // num_cities
);
  logic [CityW-1:0] num_cities;
  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic acc;
  logic [CityW-1:0] rc, rp;
  logic [TotW-1:0] bl;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) num_cities <= CityW'(2);
    else if (cfg_valid) num_cities <= cfg_data;
  end

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  tsp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .start(acc && s_axis_tuser == CmdStart),
    .sts(sts), .out_ready(m_axis_tready),
    .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
  );

  tsp_dp #(.MaxCities(MAX_CITIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .ld_en(acc && s_axis_tuser == CmdLoad),
    .ld_row(s_axis_tdata[3:0]), .ld_col(s_axis_tdata[7:4]),
    .ld_dist(s_axis_tdata[23:8]),
    .num_cities(num_cities),
    .route_city(rc), .route_position(rp), .best_length(bl),
    .last_city(m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, bl, rp, rc};
endmodule

// ===== rtl/tsp_checker.sv =====
`timescale 1ns / 1ps
`include "tsp_exhaustive_search_macros.svh"
module tsp_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [31:0] m_axis_tdata
);
  // no input taken while a route is streaming
  `TSP_ASSERT_IMPL(a_no_in_out, clk, rst, m_axis_tvalid, !s_axis_tready)
  // route starts at city 0 position 0 after idle
  `TSP_ASSERT_IMPL(a_first_zero, clk, rst,
    m_axis_tvalid && m_axis_tdata[7:4] == 4'd0, m_axis_tdata[3:0] == 4'd0)
  // after the last beat the block is ready again
  `TSP_ASSERT_NEXT(a_ready_after, clk, rst,
    m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
endmodule

bind tsp_exhaustive_search tsp_checker u_chk (
  .clk(clk), .rst(rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tlast(m_axis_tlast), .m_axis_tdata(m_axis_tdata)
);
